// ===== rtl/h2p_pkg.sv =====
// Shared types, constants and the usage translation table for the HID to PS/2 translator.
package h2p_pkg;

  localparam int InSlots = 6;
  localparam int MaxOut = 40;
  localparam logic [7:0] PrefixByte = 8'hE0;
  localparam logic [7:0] BreakBit = 8'h80;
  localparam logic [7:0] ModUsageBase = 8'hE0;

  // one translation entry
  typedef struct packed {
    logic       valid;
    logic       nobrk;
    logic       pfx;
    logic [7:0] code;
  } rom_entry_t;

  // request from the sequencer to the output queue
  typedef struct packed {
    logic       push;
    logic       fin;
    logic [7:0] data;
  } oq_req_t;

  function automatic rom_entry_t mk(input logic [7:0] c);
    mk = '{valid: 1'b1, nobrk: 1'b0, pfx: 1'b0, code: c};
  endfunction

  function automatic rom_entry_t ex(input logic [7:0] c);
    ex = '{valid: 1'b1, nobrk: 1'b0, pfx: 1'b1, code: c};
  endfunction

  function automatic rom_entry_t nb(input logic [7:0] c);
    nb = '{valid: 1'b1, nobrk: 1'b1, pfx: 1'b0, code: c};
  endfunction

  function automatic rom_entry_t rom_lookup(input logic [7:0] u);
    rom_entry_t e;
    e = '0;
    case (u)
      8'd1: e = nb(8'hFF);   8'd2: e = nb(8'hFC);
      8'd4: e = mk(8'h1E);   8'd5: e = mk(8'h30);   8'd6: e = mk(8'h2E);
      8'd7: e = mk(8'h20);   8'd8: e = mk(8'h12);   8'd9: e = mk(8'h21);
      8'd10: e = mk(8'h22);  8'd11: e = mk(8'h23);  8'd12: e = mk(8'h17);
      8'd13: e = mk(8'h24);  8'd14: e = mk(8'h25);  8'd15: e = mk(8'h26);
      8'd16: e = mk(8'h32);  8'd17: e = mk(8'h31);  8'd18: e = mk(8'h18);
      8'd19: e = mk(8'h19);  8'd20: e = mk(8'h10);  8'd21: e = mk(8'h13);
      8'd22: e = mk(8'h1F);  8'd23: e = mk(8'h14);  8'd24: e = mk(8'h16);
      8'd25: e = mk(8'h2F);  8'd26: e = mk(8'h11);  8'd27: e = mk(8'h2D);
      8'd28: e = mk(8'h15);  8'd29: e = mk(8'h2C);  8'd30: e = mk(8'h02);
      8'd31: e = mk(8'h03);  8'd32: e = mk(8'h04);  8'd33: e = mk(8'h05);
      8'd34: e = mk(8'h06);  8'd35: e = mk(8'h07);  8'd36: e = mk(8'h08);
      8'd37: e = mk(8'h09);  8'd38: e = mk(8'h0A);  8'd39: e = mk(8'h0B);
      8'd40: e = mk(8'h1C);  8'd41: e = mk(8'h01);  8'd42: e = mk(8'h0E);
      8'd43: e = mk(8'h0F);  8'd44: e = mk(8'h39);  8'd45: e = mk(8'h0C);
      8'd46: e = mk(8'h0D);  8'd47: e = mk(8'h1A);  8'd48: e = mk(8'h1B);
      8'd49: e = mk(8'h2B);  8'd50: e = mk(8'h2B);  8'd51: e = mk(8'h27);
      8'd52: e = mk(8'h28);  8'd53: e = mk(8'h29);  8'd54: e = mk(8'h33);
      8'd55: e = mk(8'h34);  8'd56: e = mk(8'h35);  8'd57: e = mk(8'h3A);
      8'd58: e = mk(8'h3B);  8'd59: e = mk(8'h3C);  8'd60: e = mk(8'h3D);
      8'd61: e = mk(8'h3E);  8'd62: e = mk(8'h3F);  8'd63: e = mk(8'h40);
      8'd64: e = mk(8'h41);  8'd65: e = mk(8'h42);  8'd66: e = mk(8'h43);
      8'd67: e = mk(8'h44);  8'd68: e = mk(8'h57);  8'd69: e = mk(8'h58);
      8'd70: e = ex(8'h37);  8'd71: e = mk(8'h46);  8'd72: e = nb(8'h00);
      8'd73: e = ex(8'h52);  8'd74: e = ex(8'h47);  8'd75: e = ex(8'h49);
      8'd76: e = ex(8'h53);  8'd77: e = ex(8'h4F);  8'd78: e = ex(8'h51);
      8'd79: e = ex(8'h4D);  8'd80: e = ex(8'h4B);  8'd81: e = ex(8'h50);
      8'd82: e = ex(8'h48);  8'd83: e = mk(8'h45);  8'd84: e = ex(8'h35);
      8'd85: e = mk(8'h37);  8'd86: e = mk(8'h4A);  8'd87: e = mk(8'h4E);
      8'd88: e = ex(8'h1C);  8'd89: e = mk(8'h4F);  8'd90: e = mk(8'h50);
      8'd91: e = mk(8'h51);  8'd92: e = mk(8'h4B);  8'd93: e = mk(8'h4C);
      8'd94: e = mk(8'h4D);  8'd95: e = mk(8'h47);  8'd96: e = mk(8'h48);
      8'd97: e = mk(8'h49);  8'd98: e = mk(8'h52);  8'd99: e = mk(8'h53);
      8'd100: e = mk(8'h56); 8'd101: e = ex(8'h5D); 8'd102: e = ex(8'h5E);
      8'd103: e = mk(8'h59); 8'd104: e = mk(8'h64); 8'd105: e = mk(8'h65);
      8'd106: e = mk(8'h66); 8'd107: e = mk(8'h67); 8'd108: e = mk(8'h68);
      8'd109: e = mk(8'h69); 8'd110: e = mk(8'h6A); 8'd111: e = mk(8'h6B);
      8'd112: e = mk(8'h6C); 8'd113: e = mk(8'h6D); 8'd114: e = mk(8'h6E);
      8'd115: e = mk(8'h76); 8'd133: e = mk(8'h7E); 8'd135: e = mk(8'h73);
      8'd136: e = mk(8'h70); 8'd137: e = mk(8'h7D); 8'd138: e = mk(8'h79);
      8'd139: e = mk(8'h7B); 8'd140: e = mk(8'h5C); 8'd144: e = nb(8'hF2);
      8'd145: e = nb(8'hF1); 8'd146: e = mk(8'h78); 8'd147: e = mk(8'h77);
      8'd148: e = mk(8'h76); 8'd224: e = mk(8'h1D); 8'd225: e = mk(8'h2A);
      8'd226: e = mk(8'h38); 8'd227: e = ex(8'h5B); 8'd228: e = ex(8'h1D);
      8'd229: e = mk(8'h36); 8'd230: e = ex(8'h38); 8'd231: e = ex(8'h5C);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/h2p_emit.sv =====
// Shared translation unit: turns one usage into the byte of the current sub-step.
module h2p_emit #(
  parameter int TABLE_ENTRIES = 232
) (
  input  logic [7:0] usage,
  input  logic       make,
  input  logic       sec,
  output logic       has,
  output logic       more,
  output logic [7:0] data
);
  import h2p_pkg::*;

  rom_entry_t e;
  logic       in_range;

  assign e = rom_lookup(usage);
  assign in_range = {1'b0, usage} < 9'(TABLE_ENTRIES);

  always_comb begin
    has  = in_range && e.valid && (make || !e.nobrk);
    more = e.pfx && !sec;
    if (more) begin
      data = PrefixByte;
    end else begin
      data = make ? e.code : (e.code | BreakBit);
    end
  end
endmodule

// ===== rtl/h2p_outq.sv =====
// Output queue: one held-back byte so the final byte of a report can be flagged.
module h2p_outq (
  input  logic                clk,
  input  logic                rst,
  input  h2p_pkg::oq_req_t    req,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          scancode,
  output logic                last_byte
);
  import h2p_pkg::*;

  logic       pend_valid;
  logic [7:0] pend;
  logic       can_push;

  assign can_push = !out_valid || out_ready;
  assign busy = pend_valid && !can_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (!busy && (req.push || req.fin) && pend_valid) begin
        out_valid <= 1'b1;
        scancode  <= pend;
        last_byte <= req.fin;
      end
      if (!busy && req.push) begin
        pend       <= req.data;
        pend_valid <= 1'b1;
      end else if (!busy && req.fin) begin
        pend_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/hid_report_to_ps2_scancodes_unit.sv =====
// Top level: report sequencer translating HID boot reports into PS/2 set 1 bytes.
// Output: a byte leaves at the next push or the final flush.
// Sequence: idle, 8 modifier steps, a break search (one compare per step, a step per empty slot),
// make steps over the active slots, then the final flush; each E0 prefix adds a step, and an output
// stall holds the sequence. The single translation unit and one-compare search set the pace.
// Reset: previous modifiers and keys cleared, active_slots set to 6, queue emptied.
module hid_report_to_ps2_scancodes_unit #(
  parameter int KEY_SLOTS = 6,
  parameter int TABLE_ENTRIES = 232
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] modifiers,
  input  logic [7:0] key_slot_0,
  input  logic [7:0] key_slot_1,
  input  logic [7:0] key_slot_2,
  input  logic [7:0] key_slot_3,
  input  logic [7:0] key_slot_4,
  input  logic [7:0] key_slot_5,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] scancode,
  output logic       last_byte
);
  import h2p_pkg::*;

  localparam int CW = $clog2(KEY_SLOTS + 1);
  localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_BRK  = 3'd2;
  localparam logic [2:0] S_MAK  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    state;
  logic [2:0]    active_slots;
  logic [7:0]    mods;
  logic [7:0]    pmods;
  logic [7:0]    cur [KEY_SLOTS];
  logic [7:0]    prev [KEY_SLOTS];
  logic [7:0]    in_keys [InSlots];
  logic [2:0]    mi;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] cnt;
  logic          sec;
  logic [5:0]    nbytes;

  logic [2:0]    mbit;
  logic          changed;
  logic          i_in;
  logic          j_in;
  logic [7:0]    ki;
  logic [7:0]    ci;
  logic          act;
  logic [7:0]    usage;
  logic          make;
  logic          has;
  logic          more;
  logic [7:0]    edata;
  logic          room;
  logic          busy;
  logic          stall;
  logic          done;
  oq_req_t       req;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);

  assign in_keys[0] = key_slot_0;
  assign in_keys[1] = key_slot_1;
  assign in_keys[2] = key_slot_2;
  assign in_keys[3] = key_slot_3;
  assign in_keys[4] = key_slot_4;
  assign in_keys[5] = key_slot_5;

  assign cnt = (int'(active_slots) > KEY_SLOTS) ? CW'(KEY_SLOTS) : CW'(active_slots);

  // emission order LCtrl, RCtrl, LShift, ... maps step to bit {step[0], step[2:1]}
  assign mbit    = {mi[0], mi[2:1]};
  assign changed = mods[mbit] ^ pmods[mbit];
  assign i_in    = i < cnt;
  assign j_in    = j < cnt;
  assign ki      = i_in ? prev[i[IW-1:0]] : 8'd0;
  assign ci      = i_in ? cur[i[IW-1:0]] : 8'd0;

  always_comb begin
    act   = 1'b0;
    usage = ki;
    make  = 1'b0;
    case (state)
      S_MOD: begin
        act   = changed;
        usage = ModUsageBase | {5'd0, mbit};
        make  = mods[mbit];
      end
      S_BRK: begin
        act   = i_in && (ki != 8'd0) && !j_in;
        usage = ki;
        make  = 1'b0;
      end
      S_MAK: begin
        act   = ci != 8'd0;
        usage = ci;
        make  = 1'b1;
      end
      default: begin
        act = 1'b0;
      end
    endcase
  end

  h2p_emit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_emit (
    .usage(usage),
    .make (make),
    .sec  (sec),
    .has  (has),
    .more (more),
    .data (edata)
  );

  assign room  = nbytes < 6'(MaxOut);
  assign stall = act && has && room && busy;
  assign done  = !act || !has || (!stall && !more);

  always_comb begin
    req.push = act && has && room && !busy;
    req.fin  = (state == S_FIN);
    req.data = edata;
  end

  h2p_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .scancode (scancode),
    .last_byte(last_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_slots <= 3'd6;
      pmods        <= 8'd0;
      for (int s = 0; s < KEY_SLOTS; s++) begin
        prev[s] <= 8'd0;
      end
      sec <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_slots <= cfg_data;
      end
      if (act && has && !stall) begin
        sec <= more;
        if (room) begin
          nbytes <= nbytes + 6'd1;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mods <= modifiers;
            for (int s = 0; s < KEY_SLOTS; s++) begin
              cur[s] <= (s < InSlots) ? in_keys[s] : 8'd0;
            end
            mi     <= 3'd0;
            nbytes <= 6'd0;
            sec    <= 1'b0;
            state  <= S_MOD;
          end
        end
        S_MOD: begin
          if (done) begin
            mi <= mi + 3'd1;
            if (mi == 3'd7) begin
              i     <= '0;
              j     <= '0;
              state <= S_BRK;
            end
          end
        end
        S_BRK: begin
          if (!i_in) begin
            i     <= '0;
            state <= S_MAK;
          end else if (ki == 8'd0) begin
            i <= i + 1'b1;
          end else if (j_in) begin
            // one key compared per cycle
            if (cur[j[IW-1:0]] == ki) begin
              i <= i + 1'b1;
              j <= '0;
            end else begin
              j <= j + 1'b1;
            end
          end else if (done) begin
            i <= i + 1'b1;
            j <= '0;
          end
        end
        S_MAK: begin
          if (!i_in) begin
            state <= S_FIN;
          end else if (done) begin
            i <= i + 1'b1;
          end
        end
        S_FIN: begin
          if (!busy) begin
            pmods <= mods;
            for (int s = 0; s < KEY_SLOTS; s++) begin
              prev[s] <= cur[s];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== dv/hid_report_to_ps2_scancodes_unit_tb.sv =====
// Testbench for the HID report to PS/2 scancode translator: directed and random reports, scoreboard check.
module hid_report_to_ps2_scancodes_unit_tb;
  import h2p_pkg::*;

  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic [7:0] code;
    logic       fin;
  } ps2_byte_t;

  class scancode_board;
    logic [7:0] prev_mods;
    logic [7:0] prev_keys[InSlots];
    logic [2:0] slots;
    ps2_byte_t  pending[$];
    int         errors;

    function void clear();
      prev_mods = '0;
      foreach (prev_keys[i]) prev_keys[i] = '0;
      slots = 3'd6;
      pending.delete();
      errors = 0;
    endfunction

    function void push_byte(logic [7:0] b);
      ps2_byte_t e;
      e.code = b;
      e.fin = 1'b0;
      pending.push_back(e);
    endfunction

    function void translate(logic [7:0] u, bit make);
      if (u < 8'd232) begin
        rom_entry_t r;
        r = rom_lookup(u);
        if (!r.valid) return;
        if (!make && r.nobrk) return;
        if (r.pfx) push_byte(PrefixByte);
        push_byte(make ? r.code : (r.code | BreakBit));
      end
    endfunction

    function void note_report(logic [7:0] mods, logic [7:0] keys[InSlots]);
      int cnt;
      int base;
      bit found;
      int order[8] = '{0, 4, 1, 5, 2, 6, 3, 7};
      base = pending.size();
      cnt = (slots > 3'd6) ? 6 : int'(slots);
      foreach (order[i])
        if (mods[order[i]] != prev_mods[order[i]])
          translate(8'hE0 + 8'(order[i]), mods[order[i]]);
      for (int i = 0; i < cnt; i++) begin
        found = 0;
        for (int j = 0; j < cnt; j++)
          if (keys[j] != 0 && keys[j] == prev_keys[i]) found = 1;
        if (prev_keys[i] != 0 && !found) translate(prev_keys[i], 0);
      end
      for (int i = 0; i < cnt; i++)
        if (keys[i] != 0) translate(keys[i], 1);
      prev_mods = mods;
      prev_keys = keys;
      if (pending.size() > base) pending[pending.size() - 1].fin = 1'b1;
    endfunction

    function void check_byte(logic [7:0] code, logic fin);
      ps2_byte_t e;
      if (pending.size() == 0) begin
        $error("unexpected scancode %02h", code);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (code !== e.code) begin
        $error("scancode: expected %02h, got %02h", e.code, code);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("last_byte: expected %0b, got %0b", e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [7:0] modifiers = '0;
  logic [7:0] key_slot_0 = '0, key_slot_1 = '0, key_slot_2 = '0;
  logic [7:0] key_slot_3 = '0, key_slot_4 = '0, key_slot_5 = '0;
  logic out_valid, out_ready = 0;
  logic [7:0] scancode;
  logic last_byte;

  scancode_board board;
  int idle_cycles;
  bit sending_done;

  hid_report_to_ps2_scancodes_unit uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_byte(scancode, last_byte);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("hid_report_to_ps2_scancodes_unit test failed");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int g;
    @(negedge clk);
    forever begin
      g = gap_len();
      out_ready <= (g == 0);
      repeat (g == 0 ? $urandom_range(1, 20) : g) @(negedge clk);
    end
  end

  // valid stays up into the next request when there is no gap
  task automatic send_report(logic [7:0] mods, logic [7:0] keys[InSlots]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    modifiers <= mods;
    {key_slot_0, key_slot_1, key_slot_2} <= {keys[0], keys[1], keys[2]};
    {key_slot_3, key_slot_4, key_slot_5} <= {keys[3], keys[4], keys[5]};
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    board.note_report(mods, keys);
    @(negedge clk);
  endtask

  task automatic write_slots(logic [2:0] v);
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    board.slots = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [7:0] pick_usage();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 70) return 8'($urandom_range(4, 115));
    if (r < 80) return 8'($urandom_range(224, 231));
    if (r < 90) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] keys[InSlots];
    logic [7:0] held[InSlots];
    logic [7:0] dir_keys[8] = '{8'd0, 8'd255, 8'd72, 8'd1, 8'd70, 8'd3, 8'd232, 8'd231};
    board = new();
    board.clear();
    idle_cycles = 0;
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes, pause, no-break, prefixed, unassigned and out-of-range usages
    foreach (keys[i]) keys[i] = 8'hFF;
    send_report(8'hFF, keys);
    foreach (keys[i]) keys[i] = 8'h00;
    send_report(8'h00, keys);
    send_report(8'h00, keys);
    for (int i = 0; i < 8; i++) begin
      foreach (keys[k]) keys[k] = dir_keys[(i + k) % 8];
      send_report(8'(1 << i), keys);
    end
    foreach (keys[i]) keys[i] = 8'(4 + i);
    send_report(8'hAA, keys);
    send_report(8'h55, keys);
    keys[2] = 8'd88;
    send_report(8'h55, keys);
    foreach (keys[i]) keys[i] = 8'h00;
    send_report(8'h00, keys);

    // random phases across slot counts, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      write_slots(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : ph == 2 ? 3'd1 : 3'($urandom_range(0, 7)));
      foreach (held[i]) held[i] = 8'h00;
      for (int n = 0; n < 50; n++) begin
        // mostly evolve the held set, a few reports fully random
        if ($urandom_range(0, 9) == 0)
          foreach (keys[i]) keys[i] = 8'($urandom_range(0, 255));
        else begin
          foreach (held[i]) if ($urandom_range(0, 3) == 0) held[i] = pick_usage();
          keys = held;
        end
        send_report(8'($urandom_range(0, 255)), keys);
      end
    end
    write_slots(3'd6);

    while (board.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("hid_report_to_ps2_scancodes_unit test passed");
    else
      $display("hid_report_to_ps2_scancodes_unit test failed");
    $finish;
  end
endmodule
